FILE: design/tlge_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tlge_pkg;

    // Default grid size.
    localparam int GRID_WIDTH_DEF  = 64;
    localparam int GRID_HEIGHT_DEF = 64;

    // Fixed field widths of the command and row channels.
    localparam int CMD_W      = 3;
    localparam int COORD_W    = 6;
    localparam int ROW_BITS_W = 64;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_STEP  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SET   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CLR   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLRALL = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;

    // B3/S23 rule: a cell is born on three neighbors and survives on two or three.
    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    // Control shared by every row cell of the chain.
    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctrl;

endpackage

`default_nettype wire

FILE: design/tlge_cmd_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tlge_cmd_if;
    import tlge_pkg::*;

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;

    modport source (output valid, cmd, cell_x, cell_y, input ready);
    modport sink   (input valid, cmd, cell_x, cell_y, output ready);
endinterface

`default_nettype wire

FILE: design/tlge_row_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tlge_row_if;
    import tlge_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [COORD_W-1:0]    row_index;
    logic [ROW_BITS_W-1:0] row_bits;
    logic                  last;

    modport source (output valid, row_index, row_bits, last, input ready);
    modport sink   (input valid, row_index, row_bits, last, output ready);
endinterface

`default_nettype wire

FILE: design/tlge_row_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module tlge_row_cell #(
    parameter int ROW_W = tlge_pkg::GRID_WIDTH_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire tlge_pkg::t_cell_ctrl i_ctrl,
    input  wire logic [ROW_W-1:0]    i_shift_in,
    output logic      [ROW_W-1:0]    o_row
);
    import tlge_pkg::*;

    logic [ROW_W-1:0] r_row;

    // One grid row; it takes its neighbor's row whenever the chain rotates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
        end else if (i_ctrl.clear) begin
            r_row <= '0;
        end else if (i_ctrl.shift) begin
            r_row <= i_shift_in;
        end
    end

    assign o_row = r_row;

endmodule

`default_nettype wire

FILE: design/tlge_row_rule.sv
`timescale 1ns / 1ps
`default_nettype none

module tlge_row_rule #(
    parameter int ROW_W = tlge_pkg::GRID_WIDTH_DEF
) (
    input  wire logic [ROW_W-1:0] i_up,
    input  wire logic [ROW_W-1:0] i_mid,
    input  wire logic [ROW_W-1:0] i_dn,
    output logic      [ROW_W-1:0] o_next
);
    import tlge_pkg::*;

    // Each column counts its eight neighbors, wrapping at both row ends.
    for (genvar x = 0; x < ROW_W; x++) begin : g_col
        localparam int XL = (x == 0) ? ROW_W - 1 : x - 1;
        localparam int XR = (x == ROW_W - 1) ? 0 : x + 1;

        logic [3:0] count;

        assign count = 4'(i_up[XL]) + 4'(i_up[x]) + 4'(i_up[XR])
                     + 4'(i_mid[XL]) + 4'(i_mid[XR])
                     + 4'(i_dn[XL]) + 4'(i_dn[x]) + 4'(i_dn[XR]);

        assign o_next[x] = (count == BIRTH_COUNT)
                        || (i_mid[x] && (count == SURVIVE_COUNT));
    end

endmodule

`default_nettype wire

FILE: design/toroidal_life_grid_engine_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Toroidal B3/S23 life engine. The grid is held as a ring of row cells that
// rotates one row per cycle, while the result register is free or being
// emptied, past a single head position, where the rule logic, the cell
// set/clear logic and the result register sit. A step, set, clear or read
// transaction makes one full turn of the ring before the engine is back in
// idle, with one row result per cycle during a step while the ring is not
// stalled. Clear-all and a row outside the grid go through a single-result
// state back to idle without turning the ring. The ring only rotates while
// the result register is free or being emptied, so output back-pressure
// stretches a turn. A new command transaction is accepted whenever the engine
// is idle, even while the last result still waits in the output register.
module toroidal_life_grid_engine_top #(
    parameter int GRID_WIDTH  = tlge_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = tlge_pkg::GRID_HEIGHT_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tlge_cmd_if.sink   i_cmd,
    tlge_row_if.source o_row
);
    import tlge_pkg::*;

    localparam int CNT_W = $clog2(GRID_HEIGHT);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_ONE  = 2'd2;

    logic [1:0]            r_state;
    logic [1:0]            n_state;
    logic [CMD_W-1:0]      r_cmd;
    logic [COORD_W-1:0]    r_cx;
    logic [COORD_W-1:0]    r_cy;
    logic [CNT_W-1:0]      r_cnt;
    logic [GRID_WIDTH-1:0] r_prev;
    logic [GRID_WIDTH-1:0] r_first;

    logic                  r_out_valid;
    logic [COORD_W-1:0]    r_out_idx;
    logic [GRID_WIDTH-1:0] r_out_bits;
    logic                  r_out_last;

    logic [GRID_WIDTH-1:0] w_row [GRID_HEIGHT];
    logic [GRID_WIDTH-1:0] w_head;
    logic [GRID_WIDTH-1:0] w_up;
    logic [GRID_WIDTH-1:0] w_dn;
    logic [GRID_WIDTH-1:0] w_rule;
    logic [GRID_WIDTH-1:0] w_mod;
    logic [GRID_WIDTH-1:0] w_head_next;

    logic       w_accept;
    logic       w_out_free;
    logic       w_advance;
    logic       w_hit;
    logic       w_cnt_last;
    logic       w_cy_out;
    logic       w_one_load;
    t_cell_ctrl w_ctrl;

    // Handshake and control.
    assign i_cmd.ready = (r_state == ST_IDLE);
    assign w_accept    = i_cmd.valid && i_cmd.ready;
    assign w_out_free  = !r_out_valid || o_row.ready;
    assign w_advance   = (r_state == ST_RUN) && w_out_free;
    assign w_one_load  = (r_state == ST_ONE) && w_out_free;
    assign w_cnt_last  = (r_cnt == CNT_W'(GRID_HEIGHT - 1));
    assign w_hit       = (COORD_W'(r_cnt) == r_cy);
    assign w_cy_out    = ({1'b0, i_cmd.cell_y} >= (COORD_W + 1)'(GRID_HEIGHT));

    assign w_ctrl.shift = w_advance;
    assign w_ctrl.clear = w_accept && (i_cmd.cmd == CMD_CLRALL);

    // Ring of row cells; the head row re-enters at the tail after processing.
    for (genvar k = 0; k < GRID_HEIGHT; k++) begin : g_ring
        logic [GRID_WIDTH-1:0] shift_in;

        if (k == GRID_HEIGHT - 1) begin : g_tail
            assign shift_in = w_head_next;
        end else begin : g_link
            assign shift_in = w_row[k+1];
        end

        tlge_row_cell #(
            .ROW_W (GRID_WIDTH)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (w_ctrl),
            .i_shift_in (shift_in),
            .o_row      (w_row[k])
        );
    end

    assign w_head = w_row[0];

    // Neighbor rows of the head: wrap to the last row on the first turn step and
    // to the saved old first row on the last one.
    assign w_up = (r_cnt == '0) ? w_row[GRID_HEIGHT-1] : r_prev;
    assign w_dn = w_cnt_last ? r_first : w_row[1];

    tlge_row_rule #(
        .ROW_W (GRID_WIDTH)
    ) u_rule (
        .i_up   (w_up),
        .i_mid  (w_head),
        .i_dn   (w_dn),
        .o_next (w_rule)
    );

    // Single-cell set or clear on the head row.
    always_comb begin
        w_mod = w_head;
        if ((r_cmd == CMD_SET) || (r_cmd == CMD_CLR)) begin
            for (int i = 0; i < GRID_WIDTH; i++) begin
                if (r_cx == COORD_W'(i)) begin
                    w_mod[i] = (r_cmd == CMD_SET);
                end
            end
        end
    end

    always_comb begin
        if (r_cmd == CMD_STEP) begin
            w_head_next = w_rule;
        end else if (w_hit) begin
            w_head_next = w_mod;
        end else begin
            w_head_next = w_head;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (i_cmd.cmd) inside
                        CMD_STEP:                   n_state = ST_RUN;
                        CMD_SET, CMD_CLR, CMD_READ: n_state = w_cy_out ? ST_ONE : ST_RUN;
                        CMD_CLRALL:                 n_state = ST_ONE;
                        default:                    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_RUN: begin
                if (w_advance && w_cnt_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_ONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (w_advance) begin
                r_cnt <= w_cnt_last ? '0 : r_cnt + 1'b1;
            end
        end
    end

    // Command capture and wrap rows kept across the turn.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_cmd.cmd;
            r_cx  <= i_cmd.cell_x;
            r_cy  <= (i_cmd.cmd == CMD_CLRALL) ? '0 : i_cmd.cell_y;
        end
        if (w_advance) begin
            r_prev <= w_head;
            if (r_cnt == '0) begin
                r_first <= w_head;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && ((r_cmd == CMD_STEP) || w_hit)) begin
            r_out_valid <= 1'b1;
        end else if (w_one_load) begin
            r_out_valid <= 1'b1;
        end else if (o_row.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && ((r_cmd == CMD_STEP) || w_hit)) begin
            r_out_idx  <= COORD_W'(r_cnt);
            r_out_bits <= w_head_next;
            r_out_last <= (r_cmd == CMD_STEP) ? w_cnt_last : 1'b1;
        end else if (w_one_load) begin
            r_out_idx  <= r_cy;
            r_out_bits <= '0;
            r_out_last <= 1'b1;
        end
    end

    assign o_row.valid     = r_out_valid;
    assign o_row.row_index = r_out_idx;
    assign o_row.row_bits  = ROW_BITS_W'(r_out_bits);
    assign o_row.last      = r_out_last;

    // A step result is flagged last exactly on the final grid row.
    a_step_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && (r_cmd == CMD_STEP)) |=>
            (o_row.valid && (o_row.last == (o_row.row_index == COORD_W'(GRID_HEIGHT - 1)))))
        else $error("step result last flag does not match row index");

    // The ring is back in row order whenever the engine is idle.
    a_idle_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_cnt == '0))
        else $error("ring not aligned while idle");

    // Clear-all leaves an empty grid and a pending single result.
    a_clear_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_cmd.cmd == CMD_CLRALL)) |=>
            ((r_state == ST_ONE) && (w_row[0] == '0) && (w_row[GRID_HEIGHT-1] == '0)))
        else $error("clear-all did not empty the grid");

    // A turn that emits a row on its final step ends in idle with a last result.
    a_turn_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_cnt_last && ((r_cmd == CMD_STEP) || w_hit)) |=>
            ((r_state == ST_IDLE) && o_row.valid && o_row.last))
        else $error("turn did not end with a last result");

endmodule

`default_nettype wire

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import tlge_pkg::*;

    localparam int GRID_W       = GRID_WIDTH_DEF;
    localparam int GRID_H       = GRID_HEIGHT_DEF;
    localparam int RANDOM_ITEMS = 460;
    localparam int HOLD_CYCLES  = 600;
    localparam int CYCLE_LIMIT  = 1_500_000;

    // Neighbor counts of the B3/S23 rule.
    localparam int BORN_ON   = 3;
    localparam int KEEP_LOW  = 2;
    localparam int KEEP_HIGH = 3;

    // Command codes above the last defined one are ignored by the block.
    localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = CMD_READ + 1'b1;

    typedef struct {
        logic [COORD_W-1:0]    row_index;
        logic [ROW_BITS_W-1:0] row_bits;
        logic                  last;
    } t_row_result;

    // Scoreboard: keeps its own copy of the grid and the queue of row results
    // that the accepted commands must produce, in order.
    class life_scoreboard;
        logic [ROW_BITS_W-1:0] grid [GRID_H];
        t_row_result           expected_rows [$];
        int                    errors;

        function new();
            clear_grid();
            errors = 0;
        endfunction

        function void clear_grid();
            for (int y = 0; y < GRID_H; y++) begin
                grid[y] = '0;
            end
        endfunction

        function void push_row(int idx, logic [ROW_BITS_W-1:0] bits, logic last);
            t_row_result r;
            r.row_index = COORD_W'(idx);
            r.row_bits  = bits;
            r.last      = last;
            expected_rows.push_back(r);
        endfunction

        // Next generation on the torus, computed from a snapshot of the old grid.
        function void advance_generation();
            logic [ROW_BITS_W-1:0] old_rows [GRID_H];
            int count;
            int nx;
            int ny;
            for (int y = 0; y < GRID_H; y++) begin
                old_rows[y] = grid[y];
            end
            for (int y = 0; y < GRID_H; y++) begin
                for (int x = 0; x < GRID_W; x++) begin
                    count = 0;
                    for (int dy = -1; dy <= 1; dy++) begin
                        for (int dx = -1; dx <= 1; dx++) begin
                            if (dx != 0 || dy != 0) begin
                                ny = (y + dy + GRID_H) % GRID_H;
                                nx = (x + dx + GRID_W) % GRID_W;
                                count += int'(old_rows[ny][nx]);
                            end
                        end
                    end
                    if (old_rows[y][x]) begin
                        grid[y][x] = (count == KEEP_LOW) || (count == KEEP_HIGH);
                    end else begin
                        grid[y][x] = (count == BORN_ON);
                    end
                end
            end
        endfunction

        // Called once per accepted command transaction.
        function void note_command(logic [CMD_W-1:0] cmd, logic [COORD_W-1:0] cx,
                                   logic [COORD_W-1:0] cy);
            case (cmd)
                CMD_STEP: begin
                    advance_generation();
                    for (int y = 0; y < GRID_H; y++) begin
                        push_row(y, grid[y], y == GRID_H - 1);
                    end
                end
                CMD_SET, CMD_CLR, CMD_READ: begin
                    if (int'(cy) >= GRID_H) begin
                        // A row outside the grid reads as empty and changes nothing.
                        push_row(int'(cy), '0, 1'b1);
                    end else begin
                        if (cmd == CMD_SET && int'(cx) < GRID_W) begin
                            grid[cy][cx] = 1'b1;
                        end else if (cmd == CMD_CLR && int'(cx) < GRID_W) begin
                            grid[cy][cx] = 1'b0;
                        end
                        push_row(int'(cy), grid[cy], 1'b1);
                    end
                end
                CMD_CLRALL: begin
                    clear_grid();
                    push_row(0, '0, 1'b1);
                end
                default: begin
                    // Unused codes produce nothing.
                end
            endcase
        endfunction

        function void check_row(logic [COORD_W-1:0] idx, logic [ROW_BITS_W-1:0] bits,
                                logic last);
            t_row_result want;
            if (expected_rows.size() == 0) begin
                $display("%0t: unexpected row transaction: index %0d bits %h last %b",
                         $time, idx, bits, last);
                errors++;
                return;
            end
            want = expected_rows.pop_front();
            if (idx !== want.row_index || bits !== want.row_bits || last !== want.last) begin
                $display("%0t: row mismatch: expected index %0d bits %h last %b, got index %0d bits %h last %b",
                         $time, want.row_index, want.row_bits, want.last, idx, bits, last);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    tlge_cmd_if cmd_if ();
    tlge_row_if row_if ();

    life_scoreboard sb = new();

    bit hold_request;
    int source_fast_run;
    int sink_fast_run;

    toroidal_life_grid_engine_top #(
        .GRID_WIDTH  (GRID_W),
        .GRID_HEIGHT (GRID_H)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_row   (row_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Wait length for one transaction, with occasional runs of back-to-back ones.
    function automatic int draw_wait(inout int fast_run);
        if (fast_run > 0) begin
            fast_run--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            fast_run = $urandom_range(10, 60);
            return 0;
        end
        return $urandom_range(0, 9);
    endfunction

    // Offer one command and hold it until the block takes it.
    task automatic send_command(logic [CMD_W-1:0] cmd, logic [COORD_W-1:0] cx,
                                logic [COORD_W-1:0] cy);
        int gap;
        gap = draw_wait(source_fast_run);
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.valid  <= 1'b1;
        cmd_if.cmd    <= cmd;
        cmd_if.cell_x <= cx;
        cmd_if.cell_y <= cy;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        sb.note_command(cmd, cx, cy);
    endtask

    // Row receiver with random stalls and one long hold-off on request.
    initial begin
        int stall;
        row_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                row_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            stall = draw_wait(sink_fast_run);
            if (stall > 0) begin
                row_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            row_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!row_if.valid) @(posedge i_clk);
        end
    end

    // Row monitor.
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && row_if.valid && row_if.ready) begin
                sb.check_row(row_if.row_index, row_if.row_bits, row_if.last);
            end
        end
    end

    // Timeout.
    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // Stimulus.
    initial begin
        int random_count;
        int pick;
        int burst;
        bit hold_done;
        logic [COORD_W-1:0] bx;
        logic [COORD_W-1:0] by;

        cmd_if.valid  <= 1'b0;
        cmd_if.cmd    <= CMD_STEP;
        cmd_if.cell_x <= '0;
        cmd_if.cell_y <= '0;
        i_rst_n       <= 1'b0;
        hold_request  = 1'b0;
        hold_done     = 1'b0;
        random_count  = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty grid after reset, then the four corners: a block that only
        // exists through wrap on both axes and must stay still.
        send_command(CMD_READ, '0, '0);
        send_command(CMD_SET, '0, '0);
        send_command(CMD_SET, COORD_W'(GRID_W - 1), '0);
        send_command(CMD_SET, '0, COORD_W'(GRID_H - 1));
        send_command(CMD_SET, COORD_W'(GRID_W - 1), COORD_W'(GRID_H - 1));
        send_command(CMD_STEP, '0, '0);
        // Three corners left: the missing one is born again.
        send_command(CMD_CLR, COORD_W'(GRID_W - 1), COORD_W'(GRID_H - 1));
        send_command(CMD_STEP, '0, '0);
        send_command(CMD_CLRALL, '1, '1);

        // Glider straddling the corner, moving across both seams.
        send_command(CMD_SET, COORD_W'(GRID_W - 1), COORD_W'(GRID_H - 2));
        send_command(CMD_SET, '0, COORD_W'(GRID_H - 1));
        send_command(CMD_SET, COORD_W'(GRID_W - 2), '0);
        send_command(CMD_SET, COORD_W'(GRID_W - 1), '0);
        send_command(CMD_SET, '0, '0);
        repeat (4) send_command(CMD_STEP, '0, '0);
        send_command(CMD_READ, '1, '0);
        send_command(CMD_READ, '0, COORD_W'(GRID_H - 1));

        // Unused codes, then clearing a dead cell and setting the same cell twice.
        for (int c = 0; c < 3; c++) begin
            send_command(CMD_FIRST_UNUSED + CMD_W'(c), '1, '1);
        end
        send_command(CMD_CLR, 6'b010101, 6'b101010);
        send_command(CMD_SET, 6'b101010, 6'b010101);
        send_command(CMD_SET, 6'b101010, 6'b010101);

        // Random part: mostly dense bursts of live cells followed by steps,
        // mixed with scattered edits, reads, clears and unused codes.
        while (random_count < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (random_count >= 150 && !hold_done) begin
                // Long receiver hold-off while commands keep coming.
                hold_done    = 1'b1;
                hold_request = 1'b1;
                repeat (3) send_command(CMD_STEP, '0, '0);
                random_count += 3;
            end else if (pick < 12) begin
                bx = COORD_W'($urandom_range(0, GRID_W - 1));
                by = COORD_W'($urandom_range(0, GRID_H - 1));
                burst = $urandom_range(4, 12);
                for (int i = 0; i < burst; i++) begin
                    send_command(CMD_SET, bx + COORD_W'($urandom_range(0, 4)),
                                 by + COORD_W'($urandom_range(0, 4)));
                end
                random_count += burst;
                burst = $urandom_range(1, 4);
                repeat (burst) send_command(CMD_STEP, COORD_W'($urandom), COORD_W'($urandom));
                random_count += burst;
            end else if (pick < 40) begin
                send_command(CMD_SET, COORD_W'($urandom_range(0, GRID_W - 1)),
                             COORD_W'($urandom_range(0, GRID_H - 1)));
                random_count++;
            end else if (pick < 54) begin
                send_command(CMD_CLR, COORD_W'($urandom_range(0, GRID_W - 1)),
                             COORD_W'($urandom_range(0, GRID_H - 1)));
                random_count++;
            end else if (pick < 70) begin
                send_command(CMD_STEP, COORD_W'($urandom), COORD_W'($urandom));
                random_count++;
            end else if (pick < 88) begin
                send_command(CMD_READ, COORD_W'($urandom),
                             COORD_W'($urandom_range(0, GRID_H - 1)));
                random_count++;
            end else if (pick < 92) begin
                send_command(CMD_CLRALL, COORD_W'($urandom), COORD_W'($urandom));
                random_count++;
            end else begin
                send_command(CMD_FIRST_UNUSED + CMD_W'($urandom_range(0, 2)),
                             COORD_W'($urandom), COORD_W'($urandom));
                random_count++;
            end
        end
        cmd_if.valid <= 1'b0;

        // Drain, then give the block a full ring turn to show any extra rows.
        while (sb.expected_rows.size() != 0) @(posedge i_clk);
        repeat (GRID_H + 16) @(posedge i_clk);

        if (sb.errors == 0 && sb.expected_rows.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: toroidal_life_grid_engine_top.f
design/tlge_pkg.sv
design/tlge_cmd_if.sv
design/tlge_row_if.sv
design/tlge_row_cell.sv
design/tlge_row_rule.sv
design/toroidal_life_grid_engine_top.sv
bench/tb.sv
